/* sv/fspa_pkg.sv */
package fspa_pkg;

  // field widths
  localparam int SLOT_W = 12;
  localparam int RUN_W = 9;
  localparam int LINK_W = SLOT_W + 1;
  localparam int REQ_W = 16;
  localparam int STATUS_W = 2;

  // pool geometry
  localparam int PAGE_SLOTS = 256;
  localparam int MAX_PAGES = 16;
  localparam int PAGES_W = $clog2(MAX_PAGES + 1);
  localparam int STORE_DEPTH = 1 << SLOT_W;
  localparam int ENTRY_W = RUN_W + LINK_W;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_MAX_REQ = 1'b0;
  localparam logic CFG_IDX_SLOTS = 1'b1;
  localparam logic [REQ_W-1:0] MAX_REQ_RESET = 16'd64;
  localparam logic [RUN_W-1:0] SLOTS_RESET = 9'd256;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_NO_PAGES = 2'd2
  } status_t;

  typedef struct packed {
    logic operation;
    logic [REQ_W-1:0] request_bytes;
    logic [SLOT_W-1:0] freed_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_t status;
  } rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0] max_request_bytes;
    logic [RUN_W-1:0] slots_per_page;
  } cfg_t;

  // one free-list entry: run length and link (msb is the link valid flag)
  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic [LINK_W-1:0] link;
  } entry_t;

  // run length of a freshly claimed page, clamped into range
  function automatic logic [RUN_W-1:0] page_run(input logic [RUN_W-1:0] spp);
    logic [RUN_W-1:0] n;
    n = spp;
    if (spp == '0) begin
      n = RUN_W'(1);
    end else if (32'(spp) > PAGE_SLOTS) begin
      n = RUN_W'(PAGE_SLOTS);
    end
    return n;
  endfunction

endpackage

/* sv/fspa_if.sv */
// request channel
interface fspa_req_if;
  logic valid;
  logic ready;
  logic operation;
  logic [fspa_pkg::REQ_W-1:0] request_bytes;
  logic [fspa_pkg::SLOT_W-1:0] freed_slot;

  modport source (output valid, operation, request_bytes, freed_slot, input ready);
  modport sink (input valid, operation, request_bytes, freed_slot, output ready);
endinterface

// result channel
interface fspa_rsp_if;
  logic valid;
  logic ready;
  logic [fspa_pkg::SLOT_W-1:0] granted_slot;
  logic [fspa_pkg::STATUS_W-1:0] status;

  modport source (output valid, granted_slot, status, input ready);
  modport sink (input valid, granted_slot, status, output ready);
endinterface

/* sv/fixed_slot_pool_allocator.sv */
// Fixed-size slot pool allocator.
// in_chan carries one transaction per operation: an allocate (request_bytes
// checked against max_request_bytes) or a free (freed_slot pushed back).
// out_chan returns exactly one transaction per operation, in order:
// granted_slot and status (ok, request too large, out of pages).
// A result passes through the input register, then the result register.
// Throughput: one operation per cycle while out_chan is not stalled. An
// allocate that empties the head run and moves to the next run holds back the
// next operation (core busy) while the entry after the new head is read back
// from the entry store (registered read).
// A stalled receiver holds the result register; the input register still
// takes one more transaction, then in_chan.ready drops until out_chan moves.
// Reset (rst_n low, synchronous) drops both registers, restores the
// configuration defaults and claims the first page as the head run.
// The cfg_ port is APB-style, always ready; write it only while idle.
module fixed_slot_pool_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  fspa_req_if.sink                     in_chan,
  fspa_rsp_if.source                   out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fspa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [fspa_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [fspa_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  fspa_pkg::cfg_t cfg;
  fspa_pkg::req_t in_item_r;
  fspa_pkg::rsp_t out_item_r;
  fspa_pkg::rsp_t core_rsp;
  logic in_vld_r;
  logic out_vld_r;
  logic core_busy;
  logic fire;

  fspa_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  fspa_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg),
    .fire (fire),
    .req  (in_item_r),
    .rsp  (core_rsp),
    .busy (core_busy)
  );

  // process the held request when the core is not busy and the result register is free or being read
  assign fire = in_vld_r && !core_busy && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.operation <= in_chan.operation;
      in_item_r.request_bytes <= in_chan.request_bytes;
      in_item_r.freed_slot <= in_chan.freed_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= core_rsp;
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.granted_slot = out_item_r.granted_slot;
  assign out_chan.status = out_item_r.status;

endmodule

/* sv/fspa_ram.sv */
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/fspa_cfg_regs.sv */
module fspa_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fspa_pkg::CFG_AW-1:0]   paddr,
  input  logic [fspa_pkg::CFG_DW-1:0]   pwdata,
  output logic [fspa_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output fspa_pkg::cfg_t                cfg
);

  logic [fspa_pkg::REQ_W-1:0] max_req_r;
  logic [fspa_pkg::RUN_W-1:0] slots_r;
  logic wr_en;
  logic reg_idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  // registers sit on 4-byte boundaries, low address bits ignored
  assign reg_idx = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= fspa_pkg::MAX_REQ_RESET;
      slots_r <= fspa_pkg::SLOTS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        fspa_pkg::CFG_IDX_MAX_REQ: max_req_r <= pwdata[fspa_pkg::REQ_W-1:0];
        fspa_pkg::CFG_IDX_SLOTS: slots_r <= pwdata[fspa_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      fspa_pkg::CFG_IDX_MAX_REQ: prdata = fspa_pkg::CFG_DW'(max_req_r);
      fspa_pkg::CFG_IDX_SLOTS: prdata = fspa_pkg::CFG_DW'(slots_r);
      default: prdata = '0;
    endcase
  end

  assign cfg.max_request_bytes = max_req_r;
  assign cfg.slots_per_page = slots_r;

endmodule

/* sv/fspa_core.sv */
module fspa_core (
  input  logic            clk,
  input  logic            rst_n,
  input  fspa_pkg::cfg_t  cfg,
  input  logic            fire,
  input  fspa_pkg::req_t  req,
  output fspa_pkg::rsp_t  rsp,
  output logic            busy
);

  // head run, held in registers
  logic                          head_valid_r, head_valid_nxt;
  logic [fspa_pkg::SLOT_W-1:0]   head_index_r, head_index_nxt;
  logic [fspa_pkg::RUN_W-1:0]    head_run_r, head_run_nxt;
  logic [fspa_pkg::LINK_W-1:0]   head_link_r, head_link_nxt;
  logic [fspa_pkg::PAGES_W-1:0]  pages_used_r, pages_used_nxt;
  // copy of the store entry that head_link points at
  fspa_pkg::entry_t              next_r, next_nxt;
  logic                          fetch_r, fetch_nxt;

  logic                          ram_we;
  logic [fspa_pkg::SLOT_W-1:0]   ram_waddr;
  fspa_pkg::entry_t              ram_wdata;
  fspa_pkg::entry_t              ram_rdata;

  logic                          claim;
  logic [fspa_pkg::SLOT_W-1:0]   eff_index;
  logic [fspa_pkg::RUN_W-1:0]    eff_run;
  logic [fspa_pkg::LINK_W-1:0]   eff_link;
  logic                          too_large;
  logic                          exhausted;

  // entry store, read address follows the cached link
  fspa_ram #(
    .WIDTH(fspa_pkg::ENTRY_W),
    .DEPTH(fspa_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(next_r.link[fspa_pkg::SLOT_W-1:0]),
    .rdata(ram_rdata)
  );

  // head as seen by an allocate, with a fresh page claimed if the list is empty
  assign claim = !head_valid_r;
  assign eff_index = claim ? fspa_pkg::SLOT_W'(32'(pages_used_r) * fspa_pkg::PAGE_SLOTS)
                           : head_index_r;
  assign eff_run = claim ? fspa_pkg::page_run(cfg.slots_per_page) : head_run_r;
  assign eff_link = claim ? '0 : head_link_r;
  assign too_large = req.request_bytes > cfg.max_request_bytes;
  assign exhausted = claim && (pages_used_r >= fspa_pkg::PAGES_W'(fspa_pkg::MAX_PAGES));

  assign busy = fetch_r;

  // free list update and result
  always_comb begin
    head_valid_nxt = head_valid_r;
    head_index_nxt = head_index_r;
    head_run_nxt = head_run_r;
    head_link_nxt = head_link_r;
    pages_used_nxt = pages_used_r;
    next_nxt = next_r;
    fetch_nxt = 1'b0;
    ram_we = 1'b0;
    ram_waddr = head_index_r;
    ram_wdata.run = head_run_r;
    ram_wdata.link = head_link_r;
    rsp.granted_slot = '0;
    rsp.status = fspa_pkg::STATUS_OK;

    // pending store read lands in the cached entry
    if (fetch_r) begin
      next_nxt = ram_rdata;
    end

    if (fire) begin
      if (req.operation == fspa_pkg::OP_FREE) begin
        // push a one-slot run, spill the old head
        if (head_valid_r) begin
          ram_we = 1'b1;
          next_nxt.run = head_run_r;
          next_nxt.link = head_link_r;
          head_link_nxt = {1'b1, head_index_r};
        end else begin
          head_link_nxt = '0;
        end
        head_index_nxt = req.freed_slot;
        head_run_nxt = fspa_pkg::RUN_W'(1);
        head_valid_nxt = 1'b1;
      end else if (too_large) begin
        rsp.status = fspa_pkg::STATUS_TOO_LARGE;
      end else if (exhausted) begin
        rsp.status = fspa_pkg::STATUS_NO_PAGES;
      end else begin
        rsp.granted_slot = eff_index;
        if (claim) begin
          pages_used_nxt = pages_used_r + fspa_pkg::PAGES_W'(1);
        end
        if (eff_run > fspa_pkg::RUN_W'(1)) begin
          // shrink the head run
          head_index_nxt = eff_index + fspa_pkg::SLOT_W'(1);
          head_run_nxt = eff_run - fspa_pkg::RUN_W'(1);
          head_link_nxt = eff_link;
          head_valid_nxt = 1'b1;
        end else if (eff_link[fspa_pkg::LINK_W-1]) begin
          // move to the next run, then refetch the entry after it
          head_index_nxt = eff_link[fspa_pkg::SLOT_W-1:0];
          head_run_nxt = next_r.run;
          head_link_nxt = next_r.link;
          head_valid_nxt = 1'b1;
          fetch_nxt = 1'b1;
        end else begin
          head_valid_nxt = 1'b0;
          head_link_nxt = '0;
          head_index_nxt = eff_index;
          head_run_nxt = eff_run;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b1;
      head_index_r <= '0;
      head_run_r <= fspa_pkg::page_run(fspa_pkg::SLOTS_RESET);
      head_link_r <= '0;
      pages_used_r <= fspa_pkg::PAGES_W'(1);
      fetch_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      head_index_r <= head_index_nxt;
      head_run_r <= head_run_nxt;
      head_link_r <= head_link_nxt;
      pages_used_r <= pages_used_nxt;
      fetch_r <= fetch_nxt;
    end
  end

  // cached entry payload
  always_ff @(posedge clk) begin
    next_r <= next_nxt;
  end

endmodule

/* sv/fspa_checker.sv */
module fspa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fspa_pkg::SLOT_W-1:0]   out_granted_slot,
  input logic [fspa_pkg::STATUS_W-1:0] out_status
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_slot) && $stable(out_status))
    else $error("result changed while stalled");

  // failed allocates report slot zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fspa_pkg::STATUS_OK |-> out_granted_slot == '0)
    else $error("nonzero slot on a failed request");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input side only backs up after it took a transaction
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(in_valid && in_ready) || $past(!in_ready))
    else $error("input stalled without a held transaction");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_granted_slot(out_chan.granted_slot),
  .out_status      (out_chan.status)
);

/* sim/fixed_slot_pool_allocator_tb.sv */
`timescale 1ns / 1ps

module fixed_slot_pool_allocator_tb;
  import fspa_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_PCT = 28;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_AW-1:0] MAX_REQ_ADDR = {CFG_IDX_MAX_REQ, 2'b00};
  localparam logic [CFG_AW-1:0] SPP_ADDR = {CFG_IDX_SLOTS, 2'b00};

  // opening transaction with an optional hand-written answer
  typedef struct {
    logic operation;
    logic [REQ_W-1:0] bytes;
    logic [SLOT_W-1:0] slot;
    bit known;
    rsp_t want;
  } opening_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  fspa_req_if req_ch ();
  fspa_rsp_if rsp_ch ();

  fixed_slot_pool_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(req_ch.sink),
    .out_chan(rsp_ch.source),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // free-list shadow of the block
  logic [REQ_W-1:0] cur_max_req;
  logic [RUN_W-1:0] cur_spp;
  logic pl_valid;
  logic [SLOT_W-1:0] pl_index;
  logic [RUN_W-1:0] pl_run;
  logic [LINK_W-1:0] pl_link;
  int pl_pages;
  entry_t pl_store [STORE_DEPTH];

  rsp_t outstanding[$];
  logic [SLOT_W-1:0] held_slots[$];
  int err_cnt = 0;
  int hold_asks = 0;
  int holds_served = 0;
  bit steady = 1'b0;

  opening_row_t opening_rows [19] = '{
    '{OP_ALLOC, 16'd0, 12'd0, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd64, 12'hFFF, 1'b1, '{12'd1, STATUS_OK}},
    '{OP_ALLOC, 16'd65, 12'd0, 1'b1, '{12'd0, STATUS_TOO_LARGE}},
    '{OP_ALLOC, 16'hFFFF, 12'd0, 1'b1, '{12'd0, STATUS_TOO_LARGE}},
    '{OP_FREE, 16'hFFFF, 12'hFFF, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_FREE, 16'd0, 12'd0, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd1, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd33, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd64, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_FREE, 16'd0, 12'hAAA, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_FREE, 16'd0, 12'h555, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_FREE, 16'd0, 12'hAAA, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd17, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd63, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd0, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd48, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_FREE, 16'd0, 12'd3, 1'b1, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd64, 12'd0, 1'b0, '{12'd0, STATUS_OK}},
    '{OP_ALLOC, 16'd65, 12'd0, 1'b1, '{12'd0, STATUS_TOO_LARGE}}
  };

  always #1 clk = ~clk;

  // failure bookkeeping, only the first few are printed
  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // claim the next page as the head run, page size clamped into range
  function automatic void open_page();
    pl_index = SLOT_W'(pl_pages * PAGE_SLOTS);
    if (cur_spp == '0) begin
      pl_run = RUN_W'(1);
    end else if (int'(cur_spp) > PAGE_SLOTS) begin
      pl_run = RUN_W'(PAGE_SLOTS);
    end else begin
      pl_run = cur_spp;
    end
    pl_link = '0;
    pl_valid = 1'b1;
    pl_pages++;
  endfunction

  // apply one transaction to the shadow free list, return its answer
  function automatic rsp_t pool_apply(input req_t r);
    rsp_t res;
    entry_t nxt;
    logic [LINK_W-1:0] back;
    res.granted_slot = '0;
    res.status = STATUS_OK;
    // free: push a one-slot run, spill the old head into the store
    if (r.operation == OP_FREE) begin
      back = '0;
      if (pl_valid) begin
        pl_store[pl_index] = '{run: pl_run, link: pl_link};
        back = {1'b1, pl_index};
      end
      pl_index = r.freed_slot;
      pl_run = RUN_W'(1);
      pl_link = back;
      pl_valid = 1'b1;
      return res;
    end
    if (r.request_bytes > cur_max_req) begin
      res.status = STATUS_TOO_LARGE;
      return res;
    end
    if (!pl_valid) begin
      if (pl_pages >= MAX_PAGES) begin
        res.status = STATUS_NO_PAGES;
        return res;
      end
      open_page();
    end
    // hand out the head slot, then shrink the run or follow the link
    res.granted_slot = pl_index;
    if (pl_run > RUN_W'(1)) begin
      pl_index = pl_index + 1'b1;
      pl_run = pl_run - 1'b1;
    end else if (pl_link[LINK_W-1]) begin
      nxt = pl_store[pl_link[SLOT_W-1:0]];
      pl_index = pl_link[SLOT_W-1:0];
      pl_run = nxt.run;
      pl_link = nxt.link;
    end else begin
      pl_valid = 1'b0;
      pl_link = '0;
    end
    return res;
  endfunction

  // random transaction, frees mostly return slots that were handed out
  function automatic req_t next_item(input int alloc_pct, input int odd_pct);
    req_t r;
    int pick;
    int k;
    r.operation = OP_ALLOC;
    r.request_bytes = REQ_W'($urandom);
    r.freed_slot = SLOT_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      pick = $urandom_range(0, 99);
      if (pick >= odd_pct) begin
        r.request_bytes = REQ_W'($urandom_range(0, int'(cur_max_req)));
      end else if (pick >= odd_pct / 2 && cur_max_req != '1) begin
        r.request_bytes = REQ_W'($urandom_range(int'(cur_max_req) + 1, 65535));
      end
    end else begin
      r.operation = OP_FREE;
      if (held_slots.size() != 0 && $urandom_range(0, 99) < 80) begin
        k = $urandom_range(0, held_slots.size() - 1);
        r.freed_slot = held_slots[k];
        held_slots.delete(k);
      end
    end
    return r;
  endfunction

  // offer one transaction, predict it once accepted
  task automatic send(input req_t r, input bit known, input rsp_t known_rsp,
                      output rsp_t pred);
    // idle cycles drawn one at a time
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= r.operation;
    req_ch.request_bytes <= r.request_bytes;
    req_ch.freed_slot <= r.freed_slot;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pred = pool_apply(r);
    outstanding.push_back(known ? known_rsp : pred);
    if (r.operation == OP_ALLOC && pred.status == STATUS_OK) begin
      held_slots.push_back(pred.granted_slot);
    end
  endtask

  // apb write: setup then access, register taken when pready is seen
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // drain the block, then reprogram both registers
  task automatic set_limits(input logic [REQ_W-1:0] max_bytes, input logic [RUN_W-1:0] spp);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(MAX_REQ_ADDR, CFG_DW'(max_bytes));
    cfg_write(SPP_ADDR, CFG_DW'(spp));
    cur_max_req = max_bytes;
    cur_spp = spp;
  endtask

  // random traffic until the wanted page count and pool-empty answers are seen, within count_lo to count_hi items
  task automatic pool_traffic(input int alloc_pct, input int odd_pct, input int count_lo,
                              input int count_hi, input int want_pages, input int want_empty,
                              input int hold_at, input int pause_at);
    int n;
    int empties;
    req_t r;
    rsp_t pred;
    n = 0;
    empties = 0;
    while (n < count_hi &&
           (n < count_lo || pl_pages < want_pages || empties < want_empty)) begin
      if (n == hold_at) begin
        hold_asks++;
      end
      // sender pause until every answer is back
      if (n == pause_at) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding.size() != 0);
      end
      r = next_item(alloc_pct, odd_pct);
      send(r, 1'b0, '0, pred);
      if (pred.status == STATUS_NO_PAGES) begin
        empties++;
      end
      n++;
    end
  endtask

  // stimulus
  initial begin
    req_t r;
    rsp_t seen;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.freed_slot = '0;
    cur_max_req = MAX_REQ_RESET;
    cur_spp = SLOTS_RESET;
    pl_pages = 0;
    open_page();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening with reset limits
    foreach (opening_rows[i]) begin
      r.operation = opening_rows[i].operation;
      r.request_bytes = opening_rows[i].bytes;
      r.freed_slot = opening_rows[i].slot;
      send(r, opening_rows[i].known, opening_rows[i].want, seen);
    end

    // widest limits, oversized page: drain page 0 and claim the next one
    set_limits(16'hFFFF, 9'h1FF);
    pool_traffic(92, 8, 40, 400, 2, 0, 60, -1);

    // narrowest limits, zero page size: run the pool dry
    set_limits(16'd16, 9'd0);
    pool_traffic(95, 8, 40, 450, 0, 4, -1, -1);

    // balanced traffic on the recycled list, no idling on either side
    steady = 1'b1;
    set_limits(REQ_W'($urandom_range(17, 65534)), 9'd256);
    pool_traffic(50, 20, 60, 60, 0, 0, -1, -1);
    steady = 1'b0;

    set_limits(REQ_W'($urandom_range(16, 200)), 9'd1);
    pool_traffic(50, 20, 60, 60, 0, 0, 20, 30);

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS fixed_slot_pool_allocator");
    end else begin
      $display("FAIL fixed_slot_pool_allocator");
    end
    $finish;
  end

  // result side: random back-pressure, long hold on request, compare in order
  initial begin
    int stall;
    rsp_t want;
    stall = 0;
    rsp_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (outstanding.size() == 0) begin
          flag_error($sformatf("result with nothing pending: slot %0d status %0d",
                               rsp_ch.granted_slot, rsp_ch.status));
        end else begin
          want = outstanding.pop_front();
          if (rsp_ch.granted_slot !== want.granted_slot || rsp_ch.status !== want.status) begin
            flag_error($sformatf("mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                                 want.granted_slot, want.status,
                                 rsp_ch.granted_slot, rsp_ch.status));
          end
        end
      end
      if (hold_asks != holds_served) begin
        holds_served++;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  initial begin
    #400000;
    $display("FAIL fixed_slot_pool_allocator");
    $finish;
  end

endmodule
